[src/assert_macros.svh]
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under an active-low reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication under an active-low reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/qes_pkg.sv]
// Shared widths, root kind codes, the divider result type and the item metadata type.
// No dependencies; used by every module of the solver.
package qes_pkg;

	localparam int DATA_W = 32;
	localparam int TOL_W  = 31;
	localparam int KIND_W = 3;
	localparam int FRAC_W = 16;
	localparam int ROOT_W = 33;   // square root bits
	localparam int RAD_W  = 66;   // discriminant magnitude
	localparam int NUM_W  = 34;   // numerator magnitude
	localparam int DEN_W  = 33;   // denominator magnitude
	localparam int QUO_W  = 33;   // quotient bits kept before saturation

	localparam logic [KIND_W-1:0] KIND_ANY     = 3'd0;
	localparam logic [KIND_W-1:0] KIND_NONE    = 3'd1;
	localparam logic [KIND_W-1:0] KIND_LINEAR  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_SQ_ONE  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_SQ_NONE = 3'd4;
	localparam logic [KIND_W-1:0] KIND_SQ_TWO  = 3'd5;

	typedef struct packed {
		logic signed [DATA_W-1:0] root;
		logic                     ovf;
	} div_res_t;

	typedef struct packed {
		logic [KIND_W-1:0]        kind;
		logic signed [DATA_W-1:0] a;
		logic signed [DATA_W-1:0] b;
		logic signed [DATA_W-1:0] c;
	} sq_meta_t;

endpackage

[src/qes_sqrt.sv]
// Pipelined integer square root, one result bit per stage.
// Depends on qes_pkg.
module qes_sqrt (
	input  logic                        clk,
	input  logic                        en,
	input  logic [qes_pkg::RAD_W-1:0]   rad,
	output logic [qes_pkg::ROOT_W-1:0]  root
);
	import qes_pkg::*;

	localparam int REM_W = RAD_W + 1;

	logic [REM_W-1:0]  rem_s  [ROOT_W];
	logic [ROOT_W-1:0] root_s [ROOT_W];
	logic [REM_W-1:0]  rem_in [ROOT_W];
	logic [ROOT_W-1:0] root_in[ROOT_W];

	for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
		localparam int K = ROOT_W - 1 - j;
		logic [REM_W-1:0] trial;

		// pick up the previous stage
		if (j == 0) begin : g_first
			assign rem_in[j]  = {1'b0, rad};
			assign root_in[j] = '0;
		end else begin : g_next
			assign rem_in[j]  = rem_s[j-1];
			assign root_in[j] = root_s[j-1];
		end

		// (r + 2^k)^2 - r^2 = r*2^(k+1) + 2^(2k)
		assign trial = ({{(REM_W-ROOT_W){1'b0}}, root_in[j]} << (K + 1))
			| (REM_W'(1) << (2 * K));

		// try the bit, keep it if the remainder allows
		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_in[j] >= trial) begin
					rem_s[j]  <= rem_in[j] - trial;
					root_s[j] <= root_in[j] | (ROOT_W'(1) << K);
				end else begin
					rem_s[j]  <= rem_in[j];
					root_s[j] <= root_in[j];
				end
			end
		end
	end

	assign root = root_s[ROOT_W-1];

endmodule

[src/qes_div.sv]
// Pipelined Q16.16 divider, one quotient bit per stage, with saturation.
// Depends on qes_pkg.
module qes_div (
	input  logic                       clk,
	input  logic                       en,
	input  logic [qes_pkg::NUM_W-1:0]  num,
	input  logic [qes_pkg::DEN_W-1:0]  den,
	input  logic                       neg,
	output qes_pkg::div_res_t          res
);
	import qes_pkg::*;

	localparam int HI_W = NUM_W - (QUO_W - FRAC_W);   // bits above the quotient window
	localparam int LO_W = QUO_W - FRAC_W;

	logic [DEN_W-1:0] rem_s [QUO_W];
	logic [QUO_W-1:0] quo_s [QUO_W];
	logic [QUO_W-1:0] low_s [QUO_W];
	logic [DEN_W-1:0] den_s [QUO_W];
	logic             neg_s [QUO_W];
	logic             big_s [QUO_W];

	logic [DEN_W-1:0] rem_in [QUO_W];
	logic [QUO_W-1:0] quo_in [QUO_W];
	logic [QUO_W-1:0] low_in [QUO_W];
	logic [DEN_W-1:0] den_in [QUO_W];
	logic             neg_in [QUO_W];
	logic             big_in [QUO_W];

	logic [DEN_W-1:0] top_bits;
	logic [QUO_W-1:0] q;

	// leading bits; a quotient of 2^QUO_W or more saturates for sure
	assign top_bits = {{(DEN_W-HI_W){1'b0}}, num[NUM_W-1:LO_W]};

	for (genvar j = 0; j < QUO_W; j++) begin : g_stage
		logic [DEN_W:0] part;

		if (j == 0) begin : g_first
			assign rem_in[j] = top_bits;
			assign quo_in[j] = '0;
			assign low_in[j] = {num[LO_W-1:0], {FRAC_W{1'b0}}};
			assign den_in[j] = den;
			assign neg_in[j] = neg;
			assign big_in[j] = top_bits >= den;
		end else begin : g_next
			assign rem_in[j] = rem_s[j-1];
			assign quo_in[j] = quo_s[j-1];
			assign low_in[j] = low_s[j-1];
			assign den_in[j] = den_s[j-1];
			assign neg_in[j] = neg_s[j-1];
			assign big_in[j] = big_s[j-1];
		end

		assign part = {rem_in[j], low_in[j][QUO_W-1-j]};

		// restoring step: subtract when the partial remainder covers the divisor
		always_ff @(posedge clk) begin
			if (en) begin
				if (part >= {1'b0, den_in[j]}) begin
					rem_s[j] <= DEN_W'(part - {1'b0, den_in[j]});
					quo_s[j] <= quo_in[j] | (QUO_W'(1) << (QUO_W - 1 - j));
				end else begin
					rem_s[j] <= part[DEN_W-1:0];
					quo_s[j] <= quo_in[j];
				end
				low_s[j] <= low_in[j];
				den_s[j] <= den_in[j];
				neg_s[j] <= neg_in[j];
				big_s[j] <= big_in[j];
			end
		end
	end

	assign q = quo_s[QUO_W-1];

	// apply sign and clamp to the Q16.16 range
	always_comb begin
		res.ovf  = 1'b0;
		res.root = '0;
		if (neg_s[QUO_W-1]) begin
			if (big_s[QUO_W-1] || q > {2'b01, {(QUO_W-2){1'b0}}}) begin
				res.ovf  = 1'b1;
				res.root = {1'b1, {(DATA_W-1){1'b0}}};
			end else begin
				res.root = -$signed(q[DATA_W-1:0]);
			end
		end else begin
			if (big_s[QUO_W-1] || q[QUO_W-1] || q[DATA_W-1]) begin
				res.ovf  = 1'b1;
				res.root = {1'b0, {(DATA_W-1){1'b1}}};
			end else begin
				res.root = $signed(q[DATA_W-1:0]);
			end
		end
	end

endmodule

[src/quadratic_equation_solver.sv]
// Solves a*x^2 + b*x + c = 0 on signed Q16.16 coefficients and returns the root kind and up
// to two saturated roots. A new beat is taken every cycle while the skid is empty; each beat
// passes three front stages, 33 square root stages, one setup stage, 33 divider stages and
// the output register, the root and divider pipelines giving one bit per stage. A one-beat
// skid behind the output register keeps input ready registered. Depends on qes_pkg, qes_sqrt
// and qes_div.
module quadratic_equation_solver (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [qes_pkg::TOL_W-1:0]          zero_tolerance,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [qes_pkg::DATA_W-1:0]  coef_a,
	input  logic signed [qes_pkg::DATA_W-1:0]  coef_b,
	input  logic signed [qes_pkg::DATA_W-1:0]  coef_c,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [qes_pkg::DATA_W-1:0]  root_first,
	output logic signed [qes_pkg::DATA_W-1:0]  root_second,
	output logic [qes_pkg::KIND_W-1:0]         root_kind,
	output logic                               overflow
);
	import qes_pkg::*;

	localparam int PROD_W = 2 * DATA_W;
	localparam int SUM_W  = RAD_W + 1;
	localparam int WIDE_W = NUM_W + 1;

	logic [TOL_W-1:0] tol_q;
	logic             en;

	// tolerance register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_W'(1);
		end else if (cfg_valid) begin
			tol_q <= zero_tolerance;
		end
	end

	function automatic logic [DATA_W-1:0] mag32(input logic signed [DATA_W-1:0] x);
		mag32 = x[DATA_W-1] ? DATA_W'(-x) : DATA_W'(x);
	endfunction

	// ---------------- stage 1: magnitudes and zero tests
	logic                     vld_s1;
	sq_meta_t                 meta_s1;
	logic [DATA_W-1:0]        ma_s1, mb_s1, mc_s1;
	logic                     za_s1, zb_s1, zc_s1;
	logic [DATA_W-1:0]        ma_in, mb_in, mc_in;

	assign ma_in = mag32(coef_a);
	assign mb_in = mag32(coef_b);
	assign mc_in = mag32(coef_c);

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s1 <= '{kind: KIND_ANY, a: coef_a, b: coef_b, c: coef_c};
			ma_s1   <= ma_in;
			mb_s1   <= mb_in;
			mc_s1   <= mc_in;
			za_s1   <= ma_in <= {1'b0, tol_q};
			zb_s1   <= mb_in <= {1'b0, tol_q};
			zc_s1   <= mc_in <= {1'b0, tol_q};
		end
	end

	// ---------------- stage 2: products b^2 and |a*c|
	logic                     vld_s2;
	sq_meta_t                 meta_s2;
	logic [PROD_W-1:0]        b2_s2, ac_s2;
	logic                     za_s2, zb_s2, zc_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s2 <= meta_s1;
			b2_s2   <= mb_s1 * mb_s1;
			ac_s2   <= ma_s1 * mc_s1;
			za_s2   <= za_s1;
			zb_s2   <= zb_s1;
			zc_s2   <= zc_s1;
		end
	end

	// ---------------- stage 3: discriminant and classification
	logic                     vld_s3;
	sq_meta_t                 meta_s3;
	logic [RAD_W-1:0]         rad_s3;
	logic                     ac_neg, dneg, dsmall;
	logic [RAD_W-1:0]         b2e, f4, dmag;
	logic [SUM_W-1:0]         d_sum, d_dif;
	logic [KIND_W-1:0]        kind_d;

	always_comb begin
		b2e    = {{(RAD_W-PROD_W){1'b0}}, b2_s2};
		f4     = {ac_s2, 2'b00};
		ac_neg = (meta_s2.a[DATA_W-1] ^ meta_s2.c[DATA_W-1]) && (ac_s2 != '0);
		d_sum  = {1'b0, b2e} + {1'b0, f4};
		d_dif  = {1'b0, b2e} - {1'b0, f4};
		dneg   = !ac_neg && d_dif[SUM_W-1];
		if (ac_neg) begin
			dmag = d_sum[RAD_W-1:0];
		end else if (d_dif[SUM_W-1]) begin
			dmag = f4 - b2e;
		end else begin
			dmag = d_dif[RAD_W-1:0];
		end
		dsmall = dmag <= {{(RAD_W-TOL_W-FRAC_W){1'b0}}, tol_q, {FRAC_W{1'b0}}};
		priority if (za_s2) begin
			if (zb_s2) begin
				kind_d = zc_s2 ? KIND_ANY : KIND_NONE;
			end else begin
				kind_d = KIND_LINEAR;
			end
		end else if (dsmall) begin
			kind_d = KIND_SQ_ONE;
		end else if (dneg) begin
			kind_d = KIND_SQ_NONE;
		end else begin
			kind_d = KIND_SQ_TWO;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s3 <= '{kind: kind_d, a: meta_s2.a, b: meta_s2.b, c: meta_s2.c};
			rad_s3  <= (kind_d == KIND_SQ_TWO) ? dmag : '0;
		end
	end

	// ---------------- square root pipeline, side line carries the item
	logic [ROOT_W-1:0]        root_d;
	sq_meta_t                 sq_meta_s [ROOT_W];
	logic [ROOT_W-1:0]        sq_vld_s;

	qes_sqrt u_sqrt (
		.clk  (clk),
		.en   (en),
		.rad  (rad_s3),
		.root (root_d)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			sq_meta_s[0] <= meta_s3;
			for (int i = 1; i < ROOT_W; i++) begin
				sq_meta_s[i] <= sq_meta_s[i-1];
			end
		end
	end

	// ---------------- stage 4: numerators and denominator
	logic                     vld_s4;
	logic [KIND_W-1:0]        kind_s4;
	logic [NUM_W-1:0]         n1_s4, n2_s4;
	logic [DEN_W-1:0]         den_s4;
	logic                     neg1_s4, neg2_s4;
	logic signed [WIDE_W-1:0] nb, nc, dd, n1, n2, dn, n1a, n2a, dna;
	sq_meta_t                 mq;

	always_comb begin
		mq  = sq_meta_s[ROOT_W-1];
		nb  = -WIDE_W'(mq.b);
		nc  = -WIDE_W'(mq.c);
		dd  = $signed({{(WIDE_W-ROOT_W){1'b0}}, root_d});
		n2  = nb + dd;
		if (mq.kind == KIND_LINEAR) begin
			n1 = nc;
			dn = WIDE_W'(mq.b);
		end else begin
			n1 = (mq.kind == KIND_SQ_TWO) ? nb - dd : nb;
			dn = WIDE_W'(mq.a) <<< 1;
		end
		n1a = n1[WIDE_W-1] ? -n1 : n1;
		n2a = n2[WIDE_W-1] ? -n2 : n2;
		dna = dn[WIDE_W-1] ? -dn : dn;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s4 <= mq.kind;
			n1_s4   <= n1a[NUM_W-1:0];
			n2_s4   <= n2a[NUM_W-1:0];
			den_s4  <= dna[DEN_W-1:0];
			neg1_s4 <= n1[WIDE_W-1] ^ dn[WIDE_W-1];
			neg2_s4 <= n2[WIDE_W-1] ^ dn[WIDE_W-1];
		end
	end

	// ---------------- divider pipelines, side line carries the kind
	div_res_t                 res1, res2;
	logic [KIND_W-1:0]        dv_kind_s [QUO_W];
	logic [QUO_W-1:0]         dv_vld_s;

	qes_div u_div_first (
		.clk (clk),
		.en  (en),
		.num (n1_s4),
		.den (den_s4),
		.neg (neg1_s4),
		.res (res1)
	);

	qes_div u_div_second (
		.clk (clk),
		.en  (en),
		.num (n2_s4),
		.den (den_s4),
		.neg (neg2_s4),
		.res (res2)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			dv_kind_s[0] <= kind_s4;
			for (int i = 1; i < QUO_W; i++) begin
				dv_kind_s[i] <= dv_kind_s[i-1];
			end
		end
	end

	// ---------------- valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			vld_s2   <= 1'b0;
			vld_s3   <= 1'b0;
			sq_vld_s <= '0;
			vld_s4   <= 1'b0;
			dv_vld_s <= '0;
		end else if (en) begin
			vld_s1   <= in_valid;
			vld_s2   <= vld_s1;
			vld_s3   <= vld_s2;
			sq_vld_s <= {sq_vld_s[ROOT_W-2:0], vld_s3};
			vld_s4   <= sq_vld_s[ROOT_W-1];
			dv_vld_s <= {dv_vld_s[QUO_W-2:0], vld_s4};
		end
	end

	// ---------------- result assembly
	logic [KIND_W-1:0]        kind_f;
	logic signed [DATA_W-1:0] r1_f, r2_f;
	logic                     ovf_f;

	always_comb begin
		kind_f = dv_kind_s[QUO_W-1];
		r1_f   = '0;
		r2_f   = '0;
		ovf_f  = 1'b0;
		unique case (kind_f)
			KIND_LINEAR, KIND_SQ_ONE: begin
				r1_f  = res1.root;
				ovf_f = res1.ovf;
			end
			KIND_SQ_TWO: begin
				r1_f  = res1.root;
				r2_f  = res2.root;
				ovf_f = res1.ovf | res2.ovf;
			end
			default: begin
				r1_f = '0;
			end
		endcase
	end

	// ---------------- output register and skid
	logic                     out_vld_q, skid_full_q;
	logic signed [DATA_W-1:0] out_r1_q, out_r2_q, skid_r1_q, skid_r2_q;
	logic [KIND_W-1:0]        out_kind_q, skid_kind_q;
	logic                     out_ovf_q, skid_ovf_q;
	logic                     deliver, take;

	assign en       = !skid_full_q;
	assign in_ready = en;
	assign deliver  = en && dv_vld_s[QUO_W-1];
	assign take     = out_vld_q && out_ready;

	// hold a waiting beat, park a new one in the skid, refill from the skid first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q   <= 1'b0;
			skid_full_q <= 1'b0;
		end else if (!out_vld_q || take) begin
			out_vld_q   <= skid_full_q || deliver;
			skid_full_q <= 1'b0;
		end else if (deliver) begin
			skid_full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || take) begin
			if (skid_full_q) begin
				out_r1_q   <= skid_r1_q;
				out_r2_q   <= skid_r2_q;
				out_kind_q <= skid_kind_q;
				out_ovf_q  <= skid_ovf_q;
			end else begin
				out_r1_q   <= r1_f;
				out_r2_q   <= r2_f;
				out_kind_q <= kind_f;
				out_ovf_q  <= ovf_f;
			end
		end else if (deliver) begin
			skid_r1_q   <= r1_f;
			skid_r2_q   <= r2_f;
			skid_kind_q <= kind_f;
			skid_ovf_q  <= ovf_f;
		end
	end

	assign out_valid   = out_vld_q;
	assign root_first  = out_r1_q;
	assign root_second = out_r2_q;
	assign root_kind   = out_kind_q;
	assign overflow    = out_ovf_q;

endmodule

[src/qes_checker.sv]
// Port-level checks for the quadratic solver, bound to the top level.
// Depends on qes_pkg and assert_macros.svh.
`include "assert_macros.svh"

module qes_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_ready,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic signed [qes_pkg::DATA_W-1:0]  root_first,
	input logic signed [qes_pkg::DATA_W-1:0]  root_second,
	input logic [qes_pkg::KIND_W-1:0]         root_kind,
	input logic                               overflow
);
	import qes_pkg::*;

	// a stalled result beat holds
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(root_first) && $stable(root_kind), "stalled result changed")

	// kinds without a root carry zero roots and no overflow
	`ASSERT_IMPLIES(a_no_root, clk, arst_n, out_valid && (root_kind == KIND_ANY || root_kind == KIND_NONE || root_kind == KIND_SQ_NONE), root_first == '0 && root_second == '0 && !overflow, "rootless result not cleared")

	// second root only for two-root kind
	`ASSERT_IMPLIES(a_second_root, clk, arst_n, out_valid && root_kind != KIND_SQ_TWO, root_second == '0, "second root set without two roots")

	// input backpressure only follows an output stall
	`ASSERT_IMPLIES(a_backpressure, clk, arst_n, !in_ready, $past(out_valid && !out_ready), "input stalled without output stall")

endmodule

bind quadratic_equation_solver qes_checker u_qes_checker (.*);

[tb/tb.sv]
// Testbench for quadratic_equation_solver: predicts the root kind, roots and overflow flag
// of each equation and compares them with the result beats. Depends on qes_pkg and the RTL.
module tb;
	import qes_pkg::*;

	localparam int STALL_LIMIT = 4000;

	typedef struct {
		logic signed [DATA_W-1:0] r1;
		logic signed [DATA_W-1:0] r2;
		logic [KIND_W-1:0]        kind;
		logic                     ovf;
	} solution_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_valid, cfg_ready;
	logic [TOL_W-1:0] zero_tolerance;
	logic in_valid, in_ready;
	logic signed [DATA_W-1:0] coef_a, coef_b, coef_c;
	logic out_valid, out_ready;
	logic signed [DATA_W-1:0] root_first, root_second;
	logic [KIND_W-1:0] root_kind;
	logic overflow;

	solution_t pending_solutions[$];
	logic [TOL_W-1:0] tol_model;
	int mismatch_count;
	int idle_pct;
	int stall_pct;
	int quiet_cycles;

	quadratic_equation_solver dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .zero_tolerance(zero_tolerance),
		.in_valid(in_valid), .in_ready(in_ready),
		.coef_a(coef_a), .coef_b(coef_b), .coef_c(coef_c),
		.out_valid(out_valid), .out_ready(out_ready),
		.root_first(root_first), .root_second(root_second),
		.root_kind(root_kind), .overflow(overflow)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Q16.16 quotient truncated toward zero, saturated, overflow flagged
	function automatic logic signed [DATA_W-1:0] fixed_div(logic signed [127:0] num,
			logic signed [127:0] den, inout logic ovf);
		logic [127:0] q;
		logic [127:0] mn, md;
		logic neg;
		mn = num < 0 ? -num : num;
		md = den < 0 ? -den : den;
		q = (mn << FRAC_W) / md;
		neg = (num < 0) != (den < 0);
		if (neg) begin
			if (q > 128'h8000_0000) begin
				ovf = 1'b1;
				return 32'sh8000_0000;
			end
			return -q[DATA_W-1:0];
		end
		if (q > 128'h7FFF_FFFF) begin
			ovf = 1'b1;
			return 32'sh7FFF_FFFF;
		end
		return q[DATA_W-1:0];
	endfunction

	function automatic logic near_zero(logic signed [127:0] v, logic [TOL_W-1:0] tol);
		return (v < 0 ? -v : v) <= {97'b0, tol};
	endfunction

	// Classify and solve one equation under the given tolerance
	function automatic solution_t solve_equation(logic signed [DATA_W-1:0] a,
			logic signed [DATA_W-1:0] b, logic signed [DATA_W-1:0] c, logic [TOL_W-1:0] tol);
		solution_t s;
		logic signed [127:0] wa, wb, wc, disc, mag, root, trial;
		logic ovf;
		wa = a;
		wb = b;
		wc = c;
		ovf = 1'b0;
		s.r1 = '0;
		s.r2 = '0;
		if (near_zero(wa, tol)) begin
			if (near_zero(wb, tol)) begin
				s.kind = near_zero(wc, tol) ? KIND_ANY : KIND_NONE;
			end else begin
				s.kind = KIND_LINEAR;
				s.r1 = fixed_div(-wc, wb, ovf);
			end
		end else begin
			disc = wb * wb - 4 * wa * wc;
			mag = disc < 0 ? -disc : disc;
			if (mag <= ({97'b0, tol} << FRAC_W)) begin
				s.kind = KIND_SQ_ONE;
				s.r1 = fixed_div(-wb, 2 * wa, ovf);
			end else if (disc < 0) begin
				s.kind = KIND_SQ_NONE;
			end else begin
				// floor square root, one bit at a time
				root = 0;
				for (int bitpos = 32; bitpos >= 0; bitpos--) begin
					trial = root | (128'sd1 <<< bitpos);
					if (trial * trial <= disc) root = trial;
				end
				s.kind = KIND_SQ_TWO;
				s.r1 = fixed_div(-wb - root, 2 * wa, ovf);
				s.r2 = fixed_div(-wb + root, 2 * wa, ovf);
			end
		end
		s.ovf = ovf;
		return s;
	endfunction

	task automatic report_mismatch(string field, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
		$display("%0t: %s got %h want %h", $realtime, field, got, want);
		mismatch_count++;
	endtask

	// Send one equation beat, idling at random beforehand
	task automatic send_equation(logic signed [DATA_W-1:0] a, logic signed [DATA_W-1:0] b,
			logic signed [DATA_W-1:0] c);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		coef_a <= a;
		coef_b <= b;
		coef_c <= c;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pending_solutions.push_back(solve_equation(a, b, c, tol_model));
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (pending_solutions.size() != 0) @(posedge clk);
	endtask

	// Write the tolerance register once the block holds nothing
	task automatic write_tolerance(logic [TOL_W-1:0] v);
		drain();
		cfg_valid <= 1'b1;
		zero_tolerance <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		tol_model = v;
	endtask

	function automatic logic signed [DATA_W-1:0] random_coef;
		case ($urandom_range(4))
			0: return $urandom;
			1: return $signed($urandom) >>> $urandom_range(31);
			2: return $signed($urandom_range(6)) - 3;
			3: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
			default: return ($signed($urandom_range(16)) - 8) <<< FRAC_W;
		endcase
	endfunction

	task automatic test_directed;
		write_tolerance(31'd1);
		send_equation(0, 0, 0);
		send_equation(1, -1, 0);
		send_equation(0, 0, 32'sh0005_0000);
		send_equation(0, 32'sh0002_0000, 32'sh0004_0000);
		send_equation(0, 2, 32'sh8000_0000);
		send_equation(0, -2, 32'sh7FFF_FFFF);
		send_equation(32'sh0001_0000, 32'sh0002_0000, 32'sh0001_0000);
		send_equation(32'sh0001_0000, 0, 32'sh0001_0000);
		send_equation(32'sh0001_0000, 0, 32'shFFFC_0000);
		// small negative discriminant still counts as one root
		send_equation(2, 0, 1);
		send_equation(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
		send_equation(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
		send_equation(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
		send_equation(2, 32'sh8000_0000, 32'sh7FFF_FFFF);
		send_equation(-2, 32'sh7FFF_FFFF, 0);
		send_equation(32'shFFFF_FFFF, 32'shFFFF_FFFF, 32'shFFFF_FFFF);
		write_tolerance(31'd0);
		send_equation(1, 0, -1);
		send_equation(0, 1, 1);
		send_equation(0, 0, 1);
		send_equation(0, 0, 0);
		write_tolerance(31'h7FFF_FFFF);
		send_equation(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000);
		send_equation(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
		send_equation(32'sh0001_0000, 0, 5);
	endtask

	task automatic test_random(int idle, int stall, int count);
		idle_pct = idle;
		stall_pct = stall;
		case ($urandom_range(3))
			0: write_tolerance(31'd1);
			1: write_tolerance(31'd0);
			2: write_tolerance(TOL_W'($urandom_range(65535)));
			default: write_tolerance(TOL_W'($urandom));
		endcase
		for (int i = 0; i < count; i++) send_equation(random_coef(), random_coef(), random_coef());
	endtask

	// Receiver stall pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= $urandom_range(99) >= stall_pct;
		end
	end

	// Compare each result beat with the oldest prediction
	always @(posedge clk) begin
		solution_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_solutions.size() == 0) begin
				$display("%0t: result beat with no equation pending", $realtime);
				mismatch_count++;
			end else begin
				want = pending_solutions.pop_front();
				if (root_first !== want.r1) report_mismatch("root_first", root_first, want.r1);
				if (root_second !== want.r2) report_mismatch("root_second", root_second, want.r2);
				if (root_kind !== want.kind) begin
					report_mismatch("root_kind", DATA_W'(root_kind), DATA_W'(want.kind));
				end
				if (overflow !== want.ovf) begin
					report_mismatch("overflow", DATA_W'(overflow), DATA_W'(want.ovf));
				end
			end
		end
	end

	// Watchdog: end the run when no beat moves for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		zero_tolerance = '0;
		in_valid = 1'b0;
		coef_a = '0;
		coef_b = '0;
		coef_c = '0;
		tol_model = 31'd1;
		mismatch_count = 0;
		idle_pct = 0;
		stall_pct = 0;
		quiet_cycles = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(0, 0, 100);
		test_random(84, 0, 100);
		test_random(0, 84, 100);
		test_random(12, 12, 50);
		test_random(0, 0, 50);
		drain();
		repeat (80) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end
endmodule

[sim.f]
+incdir+src
src/qes_pkg.sv
src/qes_sqrt.sv
src/qes_div.sv
src/quadratic_equation_solver.sv
src/qes_checker.sv
tb/tb.sv
